[rtl/epipolar_error_rms_macros.svh]
// ----------------------------------------------------------------------------
// Epipolar error RMS assertion macros
// Concurrent assertion shorthands on clk with synchronous reset rst.
// ----------------------------------------------------------------------------
`ifndef EPIPOLAR_ERROR_RMS_MACROS_SVH
`define EPIPOLAR_ERROR_RMS_MACROS_SVH

// same-cycle implication
`define EER_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eer assertion failed");

// next-cycle implication
`define EER_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eer assertion failed");

`endif

[rtl/eer_pkg.sv]
// ----------------------------------------------------------------------------
// eer_pkg
// Types, codes and helpers shared by the epipolar error RMS block.
// ----------------------------------------------------------------------------
`default_nettype none

package eer_pkg;

  localparam int EL_W  = 21;
  localparam int E_W   = 25;
  localparam int CFG_W = 63;
  localparam int PIX_W = 16;

  localparam logic signed [31:0] ONE_Q20 = 32'sd1048576;

  localparam logic [3:0] CFG_ROT0  = 4'd0;
  localparam logic [3:0] CFG_ROT1  = 4'd1;
  localparam logic [3:0] CFG_ROT2  = 4'd2;
  localparam logic [3:0] CFG_TRANS = 4'd3;
  localparam logic [3:0] CFG_FX    = 4'd4;
  localparam logic [3:0] CFG_FY    = 4'd5;
  localparam logic [3:0] CFG_CX    = 4'd6;
  localparam logic [3:0] CFG_CY    = 4'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NORM, ST_NWAIT, ST_EMAT, ST_WVEC, ST_DRES, ST_DGAP,
    ST_SQR, ST_SUM, ST_MEAN, ST_MWAIT, ST_RWAIT, ST_OUT
  } state_t;

  typedef enum logic [1:0] {MK_E, MK_W, MK_D, MK_SQ} mkind_t;

  typedef struct packed {
    logic       capture;
    logic       div_start;
    logic       div_mean;
    logic       norm_store;
    logic [1:0] nsel;
    logic       sqrt_start;
    logic       mul_en;
    mkind_t     kind;
    logic [1:0] ri;
    logic [1:0] rj;
    logic [1:0] rt;
    logic       first;
    logic       last;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic set_end;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic [1:0] tsel;
    logic [1:0] row;
    logic       sub;
  } eterm_t;

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [EL_W-1:0] el21(logic [CFG_W-1:0] pk, logic [1:0] j);
    logic signed [EL_W-1:0] r;
    case (j)
      2'd0:    r = pk[20:0];
      2'd1:    r = pk[41:21];
      default: r = pk[62:42];
    endcase
    return r;
  endfunction

  // skew(t) times R, two nonzero terms per row
  function automatic eterm_t e_term(logic [1:0] i, logic [1:0] t);
    eterm_t r;
    unique case ({i, t[0]})
      3'b000:  r = '{tsel: 2'd2, row: 2'd1, sub: 1'b1};
      3'b001:  r = '{tsel: 2'd1, row: 2'd2, sub: 1'b0};
      3'b010:  r = '{tsel: 2'd2, row: 2'd0, sub: 1'b0};
      3'b011:  r = '{tsel: 2'd0, row: 2'd2, sub: 1'b1};
      3'b100:  r = '{tsel: 2'd1, row: 2'd0, sub: 1'b1};
      3'b101:  r = '{tsel: 2'd0, row: 2'd1, sub: 1'b0};
      default: r = '{tsel: 2'd0, row: 2'd0, sub: 1'b0};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/epipolar_error_rms.sv]
// ----------------------------------------------------------------------------
// epipolar_error_rms
// Epipolar residual per matched pixel pair, with per-set RMS.
// ----------------------------------------------------------------------------
// Input beats carry one pixel pair (Q12.4) and a set_end flag on a
// valid/ready channel; output beats carry the Q12.20 residual and, on
// set_end, the set RMS with rms_valid high. One output beat per input beat.
// Pairs are worked one at a time; a set_end pair also runs the mean and
// root before its output loads, and the next pair can be accepted in the
// cycle after the output loads. The pace is set by the shared
// one-bit-per-cycle divider (four 36-step normalizations, one 64-step
// mean) and the 32-step square root; the matrix products run one multiply
// per cycle through a single 32x32 multiplier. If the receiver stalls, the
// finished pair waits inside until the output register frees, and no new
// pair is accepted meanwhile. Configuration registers are written through
// cfg_we/cfg_index/cfg_data by the user only while idle; the block does
// not enforce it. Reset restores register defaults and clears the running
// sum and pair count; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "epipolar_error_rms_macros.svh"

module epipolar_error_rms #(
  parameter int MAX_PAIRS = 4096
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [3:0]   cfg_index,
  input  wire logic [62:0]  cfg_data,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [15:0]  first_x,
  input  wire logic [15:0]  first_y,
  input  wire logic [15:0]  second_x,
  input  wire logic [15:0]  second_y,
  input  wire logic         set_end,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic signed [31:0] residual,
  output logic [31:0]       rms_error,
  output logic              rms_valid
);

  eer_pkg::cmd_t  cmd;
  eer_pkg::stat_t stat;

  eer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  eer_datapath #(.MAX_PAIRS(MAX_PAIRS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .first_x   (first_x),
    .first_y   (first_y),
    .second_x  (second_x),
    .second_y  (second_y),
    .set_end   (set_end),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .residual  (residual),
    .rms_error (rms_error),
    .rms_valid (rms_valid)
  );

  `EER_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `EER_ASSERT_NOW(a_rms_zero, out_valid && !rms_valid, rms_error == 32'd0)
  `EER_ASSERT_NOW(a_load_free, cmd.load_out, !out_valid || out_ready)

endmodule

`default_nettype wire

[rtl/eer_div.sv]
// ----------------------------------------------------------------------------
// eer_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module eer_div #(
  parameter int NW = 64,
  parameter int DW = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [NW-1:0]              num_in,
  input  wire logic [DW-1:0]              den_in,
  input  wire logic [$clog2(NW+1)-1:0]    steps,
  output logic [NW-1:0]                   quot,
  output logic                            done
);

  logic [NW-1:0]             num;
  logic [DW-1:0]             den;
  logic [DW-1:0]             rem;
  logic [$clog2(NW+1)-1:0]   cnt;
  logic [DW:0]               rem_sh;
  logic                      ge;

  assign rem_sh = {rem, num[NW-1]};
  assign ge     = rem_sh >= {1'b0, den};
  assign quot   = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= steps;
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= num_in;
      den <= den_in;
      rem <= '0;
    end else if (cnt != '0) begin
      num <= {num[NW-2:0], ge};
      rem <= ge ? DW'(rem_sh - {1'b0, den}) : rem_sh[DW-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/eer_sqrt.sv]
// ----------------------------------------------------------------------------
// eer_sqrt
// Integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module eer_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] val_in,
  output logic [31:0]      root,
  output logic             done
);

  logic [63:0] val;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;

  assign rem_sh = {rem, val[63:62]};
  assign trial  = {2'b00, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 6'd32;
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == 6'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= val_in;
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      val  <= {val[61:0], 2'b00};
      rem  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      root <= {root[30:0], ge};
    end
  end

endmodule

`default_nettype wire

[rtl/eer_datapath.sv]
// ----------------------------------------------------------------------------
// eer_datapath
// Configuration, normalization, shared multiplier and accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module eer_datapath #(
  parameter int MAX_PAIRS = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [3:0]            cfg_index,
  input  wire logic [62:0]           cfg_data,
  input  wire logic [15:0]           first_x,
  input  wire logic [15:0]           first_y,
  input  wire logic [15:0]           second_x,
  input  wire logic [15:0]           second_y,
  input  wire logic                  set_end,
  input  wire eer_pkg::cmd_t         cmd,
  output eer_pkg::stat_t             stat,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic signed [31:0]         residual,
  output logic [31:0]                rms_error,
  output logic                       rms_valid
);

  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam int DW = (CW > 16) ? CW : 16;
  localparam int SW = $clog2(65);

  logic [62:0] rot0, rot1, rot2, trans;
  logic [15:0] fx, fy, cx, cy;
  logic [15:0] px1, py1, px2, py2;
  logic        end_r;

  logic signed [31:0] y1x, y1y, y2x, y2y, d;
  logic signed [31:0] w_v [3];
  logic signed [eer_pkg::E_W-1:0] e_m [3][3];

  logic [63:0]   sum;
  logic [CW-1:0] count;

  // normalize operands
  logic [15:0]        pix, cen, foc;
  logic signed [16:0] diff;
  logic [15:0]        mag;
  logic               neg;
  logic [63:0]        div_num;
  logic [DW-1:0]      div_den;
  logic [SW-1:0]      div_steps;
  logic [63:0]        quot;
  logic [35:0]        q36;
  logic signed [31:0] norm_val;
  logic [31:0]        root;
  logic               div_done;
  logic               sqrt_done;

  always_comb begin
    unique case (cmd.nsel)
      2'd0:    begin pix = px1; cen = cx; foc = fx; end
      2'd1:    begin pix = py1; cen = cy; foc = fy; end
      2'd2:    begin pix = px2; cen = cx; foc = fx; end
      default: begin pix = py2; cen = cy; foc = fy; end
    endcase
  end

  assign diff = $signed({1'b0, pix}) - $signed({1'b0, cen});
  assign mag  = diff[16] ? 16'(-diff) : diff[15:0];

  always_comb begin
    if (cmd.div_mean) begin
      div_num   = sum;
      div_den   = DW'(count);
      div_steps = SW'(64);
    end else begin
      div_num   = {mag, 48'd0};
      div_den   = (foc == '0) ? DW'(1) : DW'(foc);
      div_steps = SW'(36);
    end
  end

  eer_div #(.NW(64), .DW(DW)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .num_in (div_num),
    .den_in (div_den),
    .steps  (div_steps),
    .quot   (quot),
    .done   (div_done)
  );

  eer_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.sqrt_start),
    .val_in (quot),
    .root   (root),
    .done   (sqrt_done)
  );

  assign q36 = quot[35:0];

  always_comb begin
    if (neg) begin
      if (q36 > 36'd2147483648) norm_val = 32'sh80000000;
      else norm_val = 32'(-$signed({1'b0, q36}));
    end else begin
      if (q36 > 36'd2147483647) norm_val = 32'sh7FFFFFFF;
      else norm_val = q36[31:0];
    end
  end

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      rot0  <= 63'd524288;
      rot1  <= 63'd1099511627776;
      rot2  <= 63'd2305843009213693952;
      trans <= '0;
      fx    <= 16'd8000;
      fy    <= 16'd8000;
      cx    <= 16'd5120;
      cy    <= 16'd3840;
    end else if (cfg_we) begin
      unique case (cfg_index)
        eer_pkg::CFG_ROT0:  rot0  <= cfg_data;
        eer_pkg::CFG_ROT1:  rot1  <= cfg_data;
        eer_pkg::CFG_ROT2:  rot2  <= cfg_data;
        eer_pkg::CFG_TRANS: trans <= cfg_data;
        eer_pkg::CFG_FX:    fx    <= cfg_data[15:0];
        eer_pkg::CFG_FY:    fy    <= cfg_data[15:0];
        eer_pkg::CFG_CX:    cx    <= cfg_data[15:0];
        eer_pkg::CFG_CY:    cy    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px1   <= first_x;
      py1   <= first_y;
      px2   <= second_x;
      py2   <= second_y;
      end_r <= set_end;
    end
    if (cmd.div_start && !cmd.div_mean) neg <= diff[16];
    if (cmd.norm_store) begin
      unique case (cmd.nsel)
        2'd0:    y1x <= norm_val;
        2'd1:    y1y <= norm_val;
        2'd2:    y2x <= norm_val;
        default: y2y <= norm_val;
      endcase
    end
  end

  assign stat = '{div_done: div_done, sqrt_done: sqrt_done, set_end: end_r,
                  out_busy: out_valid && !out_ready};

  // shared multiplier
  eer_pkg::eterm_t    et;
  logic [62:0]        rsel;
  logic signed [31:0] ma, mb;

  assign et = eer_pkg::e_term(cmd.ri, cmd.rt);

  always_comb begin
    unique case (et.row)
      2'd0:    rsel = rot0;
      2'd1:    rsel = rot1;
      default: rsel = rot2;
    endcase
  end

  always_comb begin
    unique case (cmd.kind)
      eer_pkg::MK_E: begin
        ma = 32'(eer_pkg::el21(trans, et.tsel));
        mb = 32'(eer_pkg::el21(rsel, cmd.rj));
      end
      eer_pkg::MK_W: begin
        ma = 32'(e_m[cmd.ri][cmd.rt]);
        mb = (cmd.rt == 2'd2) ? eer_pkg::ONE_Q20 : (cmd.rt == 2'd0) ? y1x : y1y;
      end
      eer_pkg::MK_D: begin
        ma = (cmd.rt == 2'd2) ? eer_pkg::ONE_Q20 : (cmd.rt == 2'd0) ? y2x : y2y;
        mb = w_v[cmd.rt];
      end
      default: begin
        ma = d;
        mb = d;
      end
    endcase
  end

  logic signed [63:0] p, acc, term, sterm, acc_new, sh18, sh20;
  logic               pv, pfirst, plast, psub;
  eer_pkg::mkind_t    pk;
  logic [1:0]         pi, pj;
  logic [64:0]        sum_add;

  always_ff @(posedge clk) begin
    if (rst) pv <= 1'b0;
    else pv <= cmd.mul_en;
  end

  always_ff @(posedge clk) begin
    p      <= 64'(ma) * 64'(mb);
    pk     <= cmd.kind;
    pi     <= cmd.ri;
    pj     <= cmd.rj;
    pfirst <= cmd.first;
    plast  <= cmd.last;
    psub   <= (cmd.kind == eer_pkg::MK_E) && et.sub;
  end

  assign term    = (pk == eer_pkg::MK_D) ? (p >>> 20) : p;
  assign sterm   = psub ? -term : term;
  assign acc_new = pfirst ? sterm : acc + sterm;
  assign sh18    = acc_new >>> 18;
  assign sh20    = acc_new >>> 20;
  assign sum_add = {1'b0, sum} + {1'b0, p};

  always_ff @(posedge clk) begin
    if (pv) begin
      acc <= acc_new;
      if (plast) begin
        unique case (pk)
          eer_pkg::MK_E: e_m[pi][pj] <= sh18[eer_pkg::E_W-1:0];
          eer_pkg::MK_W: w_v[pi]     <= eer_pkg::sat32(sh20);
          eer_pkg::MK_D: d           <= eer_pkg::sat32(acc_new);
          default: ;
        endcase
      end
    end
  end

  // running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (cmd.load_out && end_r) begin
      sum   <= '0;
      count <= '0;
    end else if (pv && pk == eer_pkg::MK_SQ) begin
      sum <= sum_add[64] ? '1 : sum_add[63:0];
      if (count < CW'(MAX_PAIRS)) count <= count + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      residual  <= d;
      rms_valid <= end_r;
      rms_error <= end_r ? root : '0;
    end
  end

endmodule

`default_nettype wire

[rtl/eer_ctrl.sv]
// ----------------------------------------------------------------------------
// eer_ctrl
// Sequencer for normalization, matrix products, mean and root.
// ----------------------------------------------------------------------------
`default_nettype none

module eer_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire eer_pkg::stat_t  stat,
  output eer_pkg::cmd_t        cmd
);

  eer_pkg::state_t state, state_next;
  logic [1:0] ci, cj, ct;

  always_ff @(posedge clk) begin
    if (rst) state <= eer_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      eer_pkg::ST_IDLE:  if (in_valid) state_next = eer_pkg::ST_NORM;
      eer_pkg::ST_NORM:  state_next = eer_pkg::ST_NWAIT;
      eer_pkg::ST_NWAIT: begin
        if (stat.div_done) state_next = (ci == 2'd3) ? eer_pkg::ST_EMAT : eer_pkg::ST_NORM;
      end
      eer_pkg::ST_EMAT: begin
        if (ci == 2'd2 && cj == 2'd2 && ct == 2'd1) state_next = eer_pkg::ST_WVEC;
      end
      eer_pkg::ST_WVEC:  if (ci == 2'd2 && ct == 2'd2) state_next = eer_pkg::ST_DRES;
      eer_pkg::ST_DRES:  if (ct == 2'd2) state_next = eer_pkg::ST_DGAP;
      eer_pkg::ST_DGAP:  state_next = eer_pkg::ST_SQR;
      eer_pkg::ST_SQR:   state_next = eer_pkg::ST_SUM;
      eer_pkg::ST_SUM:   state_next = stat.set_end ? eer_pkg::ST_MEAN : eer_pkg::ST_OUT;
      eer_pkg::ST_MEAN:  state_next = eer_pkg::ST_MWAIT;
      eer_pkg::ST_MWAIT: if (stat.div_done) state_next = eer_pkg::ST_RWAIT;
      eer_pkg::ST_RWAIT: if (stat.sqrt_done) state_next = eer_pkg::ST_OUT;
      eer_pkg::ST_OUT:   if (!stat.out_busy) state_next = eer_pkg::ST_IDLE;
      default:           state_next = eer_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ci <= '0;
      cj <= '0;
      ct <= '0;
    end else begin
      unique case (state)
        eer_pkg::ST_IDLE: begin
          ci <= '0;
          cj <= '0;
          ct <= '0;
        end
        eer_pkg::ST_NWAIT: if (stat.div_done) ci <= ci + 1'b1;
        eer_pkg::ST_EMAT: begin
          if (ct == 2'd1) begin
            ct <= '0;
            if (cj == 2'd2) begin
              cj <= '0;
              ci <= (ci == 2'd2) ? 2'd0 : ci + 1'b1;
            end else begin
              cj <= cj + 1'b1;
            end
          end else begin
            ct <= ct + 1'b1;
          end
        end
        eer_pkg::ST_WVEC: begin
          if (ct == 2'd2) begin
            ct <= '0;
            ci <= (ci == 2'd2) ? 2'd0 : ci + 1'b1;
          end else begin
            ct <= ct + 1'b1;
          end
        end
        eer_pkg::ST_DRES: ct <= (ct == 2'd2) ? 2'd0 : ct + 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.kind = eer_pkg::MK_E;
    cmd.nsel = ci;
    cmd.ri   = ci;
    cmd.rj   = cj;
    cmd.rt   = ct;
    in_ready = 1'b0;
    unique case (state)
      eer_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      eer_pkg::ST_NORM:  cmd.div_start  = 1'b1;
      eer_pkg::ST_NWAIT: cmd.norm_store = stat.div_done;
      eer_pkg::ST_EMAT: begin
        cmd.mul_en = 1'b1;
        cmd.first  = (ct == 2'd0);
        cmd.last   = (ct == 2'd1);
      end
      eer_pkg::ST_WVEC: begin
        cmd.mul_en = 1'b1;
        cmd.kind   = eer_pkg::MK_W;
        cmd.first  = (ct == 2'd0);
        cmd.last   = (ct == 2'd2);
      end
      eer_pkg::ST_DRES: begin
        cmd.mul_en = 1'b1;
        cmd.kind   = eer_pkg::MK_D;
        cmd.first  = (ct == 2'd0);
        cmd.last   = (ct == 2'd2);
      end
      eer_pkg::ST_SQR: begin
        cmd.mul_en = 1'b1;
        cmd.kind   = eer_pkg::MK_SQ;
        cmd.first  = 1'b1;
        cmd.last   = 1'b1;
      end
      eer_pkg::ST_MEAN: begin
        cmd.div_start = 1'b1;
        cmd.div_mean  = 1'b1;
      end
      eer_pkg::ST_MWAIT: cmd.sqrt_start = stat.div_done;
      eer_pkg::ST_OUT:   cmd.load_out   = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Epipolar error RMS testbench
// Drives matched pixel pairs through the valid/ready channel under random
// idling, predicts residual and set RMS in fixed point, and compares every
// output beat in order. Registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAIR_CAP  = 4096;
  localparam int STALL_CAP = 20000;

  typedef struct packed {
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] sx;
    logic [15:0] sy;
    logic        last;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] res;
    logic [31:0]        rms;
    logic               rv;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [3:0]  cfg_index;
  logic [62:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] first_x, first_y, second_x, second_y;
  logic        set_end;
  logic        out_valid;
  logic        out_ready;
  logic signed [31:0] residual;
  logic [31:0] rms_error;
  logic        rms_valid;

  epipolar_error_rms i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .first_x(first_x), .first_y(first_y), .second_x(second_x),
    .second_y(second_y), .set_end(set_end), .out_valid(out_valid),
    .out_ready(out_ready), .residual(residual), .rms_error(rms_error),
    .rms_valid(rms_valid)
  );

  logic [62:0] rot_m [3];
  logic [62:0] trans_m;
  logic [15:0] foc_x_m, foc_y_m, cen_x_m, cen_y_m;
  logic [63:0] sq_sum_m;
  int          n_pairs_m;

  pair_t    pair_q [$];
  outcome_t expect_q [$];
  int       errors;
  int       quiet_cycles;
  bit       calm;
  bit       hold_tx;
  bit       in_fire;
  int       tx_gap, rx_gap;

  function automatic logic signed [63:0] el(logic [62:0] pk, int j);
    return 64'(signed'(pk[21*j +: 21]));
  endfunction

  function automatic logic signed [63:0] sat(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] to_plane(logic [15:0] p, logic [15:0] c,
                                                  logic [15:0] f);
    logic signed [63:0] diff, div;
    diff = 64'(signed'({1'b0, p})) - 64'(signed'({1'b0, c}));
    div  = (f == 16'd0) ? 64'sd1 : 64'(signed'({1'b0, f}));
    return sat((diff * 64'sd1048576) / div);
  endfunction

  function automatic logic [31:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic outcome_t residual_of(pair_t p);
    logic signed [63:0] t [3];
    logic signed [63:0] r [3][3];
    logic signed [63:0] k [3][3];
    logic signed [63:0] e [3][3];
    logic signed [63:0] a [3];
    logic signed [63:0] b [3];
    logic signed [63:0] w [3];
    logic signed [63:0] d;
    logic [63:0] sq;
    outcome_t o;
    for (int i = 0; i < 3; i++) begin
      t[i] = el(trans_m, i);
      for (int j = 0; j < 3; j++) r[i][j] = el(rot_m[i], j);
    end
    k[0][0] = 64'sd0; k[0][1] = -t[2];  k[0][2] = t[1];
    k[1][0] = t[2];   k[1][1] = 64'sd0; k[1][2] = -t[0];
    k[2][0] = -t[1];  k[2][1] = t[0];   k[2][2] = 64'sd0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        e[i][j] = (k[i][0]*r[0][j] + k[i][1]*r[1][j] + k[i][2]*r[2][j]) >>> 18;
    a[0] = to_plane(p.fx, cen_x_m, foc_x_m);
    a[1] = to_plane(p.fy, cen_y_m, foc_y_m);
    a[2] = 64'sd1048576;
    b[0] = to_plane(p.sx, cen_x_m, foc_x_m);
    b[1] = to_plane(p.sy, cen_y_m, foc_y_m);
    b[2] = 64'sd1048576;
    d = 64'sd0;
    for (int i = 0; i < 3; i++) begin
      w[i] = sat((e[i][0]*a[0] + e[i][1]*a[1] + e[i][2]*a[2]) >>> 20);
      d = d + ((b[i] * w[i]) >>> 20);
    end
    d = sat(d);
    sq = d * d;
    sq_sum_m = (sq_sum_m > ~64'd0 - sq) ? ~64'd0 : sq_sum_m + sq;
    if (n_pairs_m < PAIR_CAP) n_pairs_m++;
    o.res = d[31:0];
    o.rms = '0;
    o.rv  = 1'b0;
    if (p.last) begin
      o.rms = root64(sq_sum_m / 64'(n_pairs_m));
      o.rv  = 1'b1;
      sq_sum_m  = '0;
      n_pairs_m = 0;
    end
    return o;
  endfunction

  task automatic write_reg(logic [3:0] idx, logic [62:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      eer_pkg::CFG_ROT0:  rot_m[0] = val;
      eer_pkg::CFG_ROT1:  rot_m[1] = val;
      eer_pkg::CFG_ROT2:  rot_m[2] = val;
      eer_pkg::CFG_TRANS: trans_m = val;
      eer_pkg::CFG_FX:    foc_x_m = val[15:0];
      eer_pkg::CFG_FY:    foc_y_m = val[15:0];
      eer_pkg::CFG_CX:    cen_x_m = val[15:0];
      eer_pkg::CFG_CY:    cen_y_m = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [62:0] rnd63();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic logic [62:0] pack3(int a, int b, int c);
    return {21'(c), 21'(b), 21'(a)};
  endfunction

  function automatic logic [15:0] rpix();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_pair(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                           logic [15:0] d, logic e);
    pair_t p;
    p = '{fx: a, fy: b, sx: c, sy: d, last: e};
    pair_q.insert(pair_q.size(), p);
  endtask

  task automatic drain();
    wait (pair_q.size() == 0 && !in_valid);
    wait (expect_q.size() == 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_sets(int n, bit wild);
    int left;
    left = n;
    while (left > 0) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 12);
      for (int i = 0; i < len && left > 0; i++) begin
        logic [15:0] u1, v1;
        u1 = wild ? rpix() : 16'(cen_x_m + $urandom_range(0, 4000) - 2000);
        v1 = wild ? rpix() : 16'(cen_y_m + $urandom_range(0, 4000) - 2000);
        push_pair(u1, v1, wild ? rpix() : 16'(u1 + $urandom_range(0, 400) - 200),
                  wild ? rpix() : 16'(v1 + $urandom_range(0, 400) - 200),
                  (i == len - 1) || ($urandom_range(0, 30) == 0));
        left--;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    in_fire <= !rst && in_valid && in_ready;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else if (!in_valid || in_fire) begin
      if (tx_gap > 0) begin
        tx_gap   <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        tx_gap   <= $urandom_range(0, 16);
        in_valid <= 1'b0;
      end else if (pair_q.size() > 0 && !hold_tx) begin
        pair_t p;
        p = pair_q.pop_front();
        in_valid <= 1'b1;
        first_x  <= p.fx;
        first_y  <= p.fy;
        second_x <= p.sx;
        second_y <= p.sy;
        set_end  <= p.last;
        expect_q.insert(expect_q.size(), residual_of(p));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap    <= 0;
    end else if (rx_gap > 0) begin
      rx_gap    <= rx_gap - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rx_gap    <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && out_ready) begin
        if (expect_q.size() == 0) begin
          $display("%0t: unexpected beat residual=%0d", $realtime, residual);
          errors++;
        end else begin
          outcome_t x;
          x = expect_q.pop_front();
          if (residual !== x.res) begin
            $display("%0t: residual expected %0d actual %0d", $realtime, x.res, residual);
            errors++;
          end
          if (rms_valid !== x.rv) begin
            $display("%0t: rms_valid expected %0b actual %0b", $realtime, x.rv, rms_valid);
            errors++;
          end
          if (rms_error !== x.rms) begin
            $display("%0t: rms_error expected %0d actual %0d", $realtime, x.rms, rms_error);
            errors++;
          end
        end
      end
      if (quiet_cycles >= STALL_CAP) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; out_ready = 1'b0;
    first_x = '0; first_y = '0; second_x = '0; second_y = '0; set_end = 1'b0;
    errors = 0; quiet_cycles = 0; calm = 1'b0; hold_tx = 1'b0; in_fire = 1'b0;
    rot_m[0] = 63'd524288; rot_m[1] = 63'd1099511627776;
    rot_m[2] = 63'd2305843009213693952; trans_m = '0;
    foc_x_m = 16'd8000; foc_y_m = 16'd8000; cen_x_m = 16'd5120; cen_y_m = 16'd3840;
    sq_sum_m = '0; n_pairs_m = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // identity rotation, zero translation: all residuals zero
    push_pair(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
    drain();
    write_reg(eer_pkg::CFG_TRANS, pack3(300000, -200000, 100000));
    write_reg(eer_pkg::CFG_ROT0, pack3(-1048576, 0, 1048575));
    push_pair(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    push_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_pair(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b1);
    push_pair(16'd5120, 16'd3840, 16'd5120, 16'd3840, 1'b1);
    drain();
    // zero focal length and extreme centers
    write_reg(eer_pkg::CFG_FX, 63'd0);
    write_reg(eer_pkg::CFG_FY, 63'd1);
    write_reg(eer_pkg::CFG_CX, 63'h0FFFF);
    write_reg(eer_pkg::CFG_CY, 63'd0);
    write_reg(eer_pkg::CFG_TRANS, pack3(-1048576, 1048575, -1048576));
    write_reg(eer_pkg::CFG_ROT1, pack3(1048575, -1048576, 1048575));
    write_reg(eer_pkg::CFG_ROT2, pack3(-1048576, 1048575, 1048575));
    push_pair(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
    push_pair(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 1'b0);
    push_pair(16'd1234, 16'd4321, 16'd777, 16'd65000, 1'b1);
    drain();
    write_reg(4'd15, rnd63());
    // long set with wild pixels
    write_reg(eer_pkg::CFG_FX, 63'h0FFFF);
    write_reg(eer_pkg::CFG_FY, 63'h0FFFF);
    write_reg(eer_pkg::CFG_CX, 63'd0);
    write_reg(eer_pkg::CFG_CY, 63'h08000);
    calm = 1'b1;
    for (int i = 0; i < 300; i++)
      push_pair(rpix(), rpix(), rpix(), rpix(), i == 299);
    drain();
    calm = 1'b0;
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(eer_pkg::CFG_ROT0, rnd63());
      write_reg(eer_pkg::CFG_ROT1, rnd63());
      write_reg(eer_pkg::CFG_ROT2, rnd63());
      write_reg(eer_pkg::CFG_TRANS, rnd63());
      write_reg(eer_pkg::CFG_FX, 63'($urandom_range(1, 65535)));
      write_reg(eer_pkg::CFG_FY, 63'($urandom_range(1, 65535)));
      write_reg(eer_pkg::CFG_CX, 63'(16'($urandom)));
      write_reg(eer_pkg::CFG_CY, 63'(16'($urandom)));
      random_sets(200, 1'b0);
      random_sets(80, phase[0]);
      if (phase == 2) begin
        wait (pair_q.size() == 0 && !in_valid);
        hold_tx = 1'b1;
        wait (expect_q.size() == 0);
        hold_tx = 1'b0;
        random_sets(20, 1'b1);
      end
      if (phase == 4) calm = 1'b1;
      drain();
    end

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/eer_pkg.sv
rtl/eer_div.sv
rtl/eer_sqrt.sv
rtl/eer_datapath.sv
rtl/eer_ctrl.sv
rtl/epipolar_error_rms.sv
tb/sv/tb.sv
